// ===== sv/priority_task_scheduler_assert.svh =====
// Assertion macros for the scheduler. They expand to nothing in synthesis.
`ifndef PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define PTS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also holds during reset
`define PTS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PTS_ASSERT(name, prop, msg)
`define PTS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== sv/pts_pkg.sv =====
`default_nettype none

package pts_pkg;

    localparam int TASK_COUNT   = 8;
    localparam int IDX_W        = $clog2(TASK_COUNT);

    // fixed field widths
    localparam int FUNC_W       = 2;
    localparam int TASK_FIELD_W = 3;
    localparam int STACK_W      = 16;
    localparam int DTICK_W      = 8;
    localparam int MASK_W       = 8;
    localparam int DELAY_W      = 7;

    localparam logic [DTICK_W-1:0] DELAY_LIMIT    = 8'd100;
    localparam logic [DTICK_W-1:0] DELAY_FALLBACK = 8'd10;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK   = 2'd0,
        FN_CREATE = 2'd1,
        FN_DELAY  = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PICK,
        S_CREATE,
        S_DELAY,
        S_SELECT,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic walk;
        logic pick;
        logic create;
        logic delay_upd;
        logic select;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic walk_last;
    } sts_t;

    // lowest set bit; the idle task when nothing is ready
    function automatic logic [IDX_W-1:0] best_ready(input logic [TASK_COUNT-1:0] m);
        logic [IDX_W-1:0] best;
        best = IDX_W'(TASK_COUNT - 1);
        for (int i = TASK_COUNT - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                best = IDX_W'(i);
            end
        end
        return best;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pts_ram.sv =====
`default_nettype none

module pts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/pts_ctrl.sv =====
`default_nettype none

module pts_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pts_pkg::FUNC_W-1:0]    func,
    input  wire pts_pkg::sts_t                 sts,
    output pts_pkg::cmd_t                      cmd,
    output logic                               busy
);

    pts_pkg::state_t state_reg;
    pts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            pts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (pts_pkg::func_t'(func))
                        pts_pkg::FN_TICK:   state_next = pts_pkg::S_WALK;
                        pts_pkg::FN_CREATE: state_next = pts_pkg::S_CREATE;
                        pts_pkg::FN_DELAY:  state_next = pts_pkg::S_DELAY;
                        default:            state_next = pts_pkg::S_READ;
                    endcase
                end
            end
            pts_pkg::S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = pts_pkg::S_PICK;
                end
            end
            pts_pkg::S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = pts_pkg::S_READ;
            end
            pts_pkg::S_CREATE:
            begin
                cmd.create = 1'b1;
                state_next = pts_pkg::S_READ;
            end
            pts_pkg::S_DELAY:
            begin
                cmd.delay_upd = 1'b1;
                state_next    = pts_pkg::S_SELECT;
            end
            pts_pkg::S_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = pts_pkg::S_READ;
            end
            pts_pkg::S_READ:
            begin
                state_next = pts_pkg::S_DONE;
            end
            pts_pkg::S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = pts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != pts_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== sv/pts_datapath.sv =====
`default_nettype none

`include "priority_task_scheduler_assert.svh"

module pts_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pts_pkg::cmd_t                       cmd,
    output pts_pkg::sts_t                            sts,
    input  wire logic [pts_pkg::TASK_FIELD_W-1:0]    task_index,
    input  wire logic [pts_pkg::STACK_W-1:0]         stack_value,
    input  wire logic [pts_pkg::DTICK_W-1:0]         delay_ticks,
    output logic                                     done,
    output logic [pts_pkg::TASK_FIELD_W-1:0]         running_task,
    output logic                                     switched,
    output logic [pts_pkg::MASK_W-1:0]               ready_mask,
    output logic [pts_pkg::STACK_W-1:0]              resume_stack
);

    localparam int N  = pts_pkg::TASK_COUNT;
    localparam int IW = pts_pkg::IDX_W;

    // transaction capture
    logic [pts_pkg::TASK_FIELD_W-1:0] idx_reg, idx_next;
    logic [pts_pkg::STACK_W-1:0]      sp_reg, sp_next;
    logic [pts_pkg::DTICK_W-1:0]      dt_reg, dt_next;

    // scheduler state
    logic [N-1:0]                     ready_reg, ready_next;
    logic [IW-1:0]                    running_reg, running_next;
    logic [pts_pkg::DELAY_W-1:0]      delay_reg [N];
    logic [pts_pkg::DELAY_W-1:0]      delay_next [N];
    logic                             sw_reg, sw_next;
    logic [IW-1:0]                    walk_cnt_reg, walk_cnt_next;

    // result register
    logic                             done_reg, done_next;
    logic [pts_pkg::TASK_FIELD_W-1:0] run_out_reg, run_out_next;
    logic                             sw_out_reg, sw_out_next;
    logic [pts_pkg::MASK_W-1:0]       mask_out_reg, mask_out_next;
    logic [pts_pkg::STACK_W-1:0]      stack_out_reg, stack_out_next;

    // stack store
    logic                             ram_we;
    logic [IW-1:0]                    ram_waddr;
    logic [pts_pkg::STACK_W-1:0]      ram_rdata;

    logic [pts_pkg::DELAY_W-1:0]      walk_cur;
    logic [pts_pkg::DTICK_W-1:0]      dt_clamped;
    logic [IW-1:0]                    best;
    logic                             idx_ok;

    pts_ram #(
        .WIDTH (pts_pkg::STACK_W),
        .DEPTH (N)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sp_reg),
        .raddr (running_reg),
        .rdata (ram_rdata)
    );

    assign walk_cur   = delay_reg[walk_cnt_reg];
    assign dt_clamped = (dt_reg > pts_pkg::DELAY_LIMIT) ? pts_pkg::DELAY_FALLBACK : dt_reg;
    assign best       = pts_pkg::best_ready(ready_reg);
    assign idx_ok     = (32'(idx_reg) < N);

    assign sts.walk_last = (walk_cnt_reg == IW'(N - 1));

    always_comb
    begin
        idx_next       = idx_reg;
        sp_next        = sp_reg;
        dt_next        = dt_reg;
        ready_next     = ready_reg;
        running_next   = running_reg;
        delay_next     = delay_reg;
        sw_next        = sw_reg;
        walk_cnt_next  = walk_cnt_reg;
        done_next      = 1'b0;
        run_out_next   = run_out_reg;
        sw_out_next    = sw_out_reg;
        mask_out_next  = mask_out_reg;
        stack_out_next = stack_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = running_reg;

        if (cmd.capture)
        begin
            idx_next      = task_index;
            sp_next       = stack_value;
            dt_next       = delay_ticks;
            sw_next       = 1'b0;
            walk_cnt_next = '0;
        end

        // one counter per cycle through the shared decrementer
        if (cmd.walk)
        begin
            if (walk_cur != '0)
            begin
                delay_next[walk_cnt_reg] = walk_cur - 1'b1;
                if (walk_cur == pts_pkg::DELAY_W'(1))
                begin
                    ready_next[walk_cnt_reg] = 1'b1;
                end
            end
            walk_cnt_next = walk_cnt_reg + 1'b1;
        end

        // preempt only for a strictly more urgent task
        if (cmd.pick)
        begin
            if (running_reg > best)
            begin
                ram_we       = 1'b1;
                running_next = best;
                sw_next      = 1'b1;
            end
        end

        if (cmd.create)
        begin
            if (idx_ok)
            begin
                ram_we                    = 1'b1;
                ram_waddr                 = idx_reg[IW-1:0];
                ready_next[idx_reg[IW-1:0]] = 1'b1;
            end
        end

        if (cmd.delay_upd)
        begin
            ram_we                  = 1'b1;
            delay_next[running_reg] = dt_clamped[pts_pkg::DELAY_W-1:0];
            ready_next[running_reg] = 1'b0;
        end

        if (cmd.select)
        begin
            running_next = best;
            sw_next      = 1'b1;
        end

        if (cmd.finish)
        begin
            done_next      = 1'b1;
            run_out_next   = pts_pkg::TASK_FIELD_W'(running_reg);
            sw_out_next    = sw_reg;
            mask_out_next  = pts_pkg::MASK_W'(ready_reg);
            stack_out_next = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg    <= {1'b1, {(N-1){1'b0}}};
            running_reg  <= IW'(N - 1);
            delay_reg    <= '{default: '0};
            sw_reg       <= 1'b0;
            walk_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            ready_reg    <= ready_next;
            running_reg  <= running_next;
            delay_reg    <= delay_next;
            sw_reg       <= sw_next;
            walk_cnt_reg <= walk_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        sp_reg        <= sp_next;
        dt_reg        <= dt_next;
        run_out_reg   <= run_out_next;
        sw_out_reg    <= sw_out_next;
        mask_out_reg  <= mask_out_next;
        stack_out_reg <= stack_out_next;
    end

    assign done         = done_reg;
    assign running_task = run_out_reg;
    assign switched     = sw_out_reg;
    assign ready_mask   = mask_out_reg;
    assign resume_stack = stack_out_reg;

    `PTS_ASSERT(a_single_strobe, done_reg |=> !done_reg, "result strobe held for two cycles")
    `PTS_ASSERT(a_select_best, cmd.select |=> (ready_reg[running_reg] || (ready_reg == '0 && running_reg == IW'(N - 1))), "selected task is neither ready nor idle")
    `PTS_ASSERT(a_switch_source, $rose(sw_reg) |-> $past(cmd.pick || cmd.select), "switch flag set outside a selection step")
    `PTS_ASSERT_ALWAYS(a_one_update, $countones({cmd.walk, cmd.pick, cmd.create, cmd.delay_upd, cmd.select, cmd.finish}) <= 1, "two update steps in one cycle")

endmodule

`default_nettype wire

// ===== sv/priority_task_scheduler.sv =====
`default_nettype none

// Priority bitmap scheduler for TASK_COUNT tasks, index 0 most urgent, last index idle.
// Command channel: an event transaction is taken on a rising edge with start high and
// busy low; func, task_index, stack_value and delay_ticks are sampled at that edge.
// Result channel: done pulses high for exactly one cycle with running_task, switched,
// ready_mask and resume_stack valid in that cycle. The receiver cannot stall; the
// result sits in its own register, so the next start is taken in the done cycle.
// Steps after the accepting edge, each a sequencer state, then READ and DONE:
//   tick            WALK over every delay counter, then PICK
//   create          CREATE
//   delay           DELAY, then SELECT
//   unused func     no step of its own
// A tick walks the delay counters one per cycle through the single decrementer; every
// event ends with a registered read of the saved-stack RAM.
// Reset (rst_n low, asynchronous): only the idle task ready and running, all delay
// counters zero, no result pending. Saved stacks are undefined until written.
module priority_task_scheduler (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // command channel
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [pts_pkg::FUNC_W-1:0]          func,
    input  wire logic [pts_pkg::TASK_FIELD_W-1:0]    task_index,
    input  wire logic [pts_pkg::STACK_W-1:0]         stack_value,
    input  wire logic [pts_pkg::DTICK_W-1:0]         delay_ticks,
    // result channel
    output logic                                     done,
    output logic [pts_pkg::TASK_FIELD_W-1:0]         running_task,
    output logic                                     switched,
    output logic [pts_pkg::MASK_W-1:0]               ready_mask,
    output logic [pts_pkg::STACK_W-1:0]              resume_stack
);

    pts_pkg::cmd_t cmd;
    pts_pkg::sts_t sts;

    // sequencer: one state per step of the event
    pts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // ready mask, delay counters, running index, stack RAM and result register
    pts_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .task_index   (task_index),
        .stack_value  (stack_value),
        .delay_ticks  (delay_ticks),
        .done         (done),
        .running_task (running_task),
        .switched     (switched),
        .ready_mask   (ready_mask),
        .resume_stack (resume_stack)
    );

endmodule

`default_nettype wire
